// File: rtl/core/kdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_pkg: shared types, constants and helpers for the key debounce unit
// Widths, reset values and register indexes used by the lanes, the merge
// stage and the top level.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int NUM_KEYS   = 3;
    localparam int TIMER_BITS = 16;

    localparam int ELAPSED_W  = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MASK_W     = 3;
    localparam int WAKE_W     = 2;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_KEY    = 2'd3;

    localparam logic [CFG_W-1:0]  RST_DEBOUNCE_MS   = 16'd20;
    localparam logic [CFG_W-1:0]  RST_LONG_PRESS_MS = 16'd1500;
    localparam logic [MASK_W-1:0] RST_POLARITY      = 3'd5;
    localparam logic [WAKE_W-1:0] RST_WAKE_KEY      = 2'd1;

    typedef logic [TIMER_BITS-1:0] t_timer;

    // per-sample values that every lane sees
    typedef struct packed {
        logic                 primed;
        logic                 bl_off;
        logic [ELAPSED_W-1:0] elapsed;
        logic [CFG_W-1:0]     debounce;
        logic [CFG_W-1:0]     long_press;
    } t_lane_ctl;

    // what one lane found on one sample
    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic activity;
    } t_lane_evt;

    // saturating timer advance
    function automatic t_timer sat_add(input t_timer a, input logic [ELAPSED_W-1:0] b);
        logic [TIMER_BITS:0] s;
        s = {1'b0, a} + (TIMER_BITS + 1)'(b);
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/key_debounce_long_press_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_unit: debounced keys with short and long press
// Result: the word is registered and valid in the cycle after it is accepted.
// Throughput: one word per cycle while the output is taken; the output register frees as it is taken.
// Reset (synchronous, active low) restores the register defaults, clears all
// key state and the primed flag, and empties the output register.
// ----------------------------------------------------------------------------
module key_debounce_long_press_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kdlp_pkg::CFG_W-1:0]     i_cfg_data,
    // sample input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [kdlp_pkg::MASK_W-1:0]    i_pin_levels,
    input  logic [kdlp_pkg::ELAPSED_W-1:0] i_elapsed_ms,
    input  logic                           i_backlight_off,
    // event output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [kdlp_pkg::MASK_W-1:0]    o_short_press_mask,
    output logic [kdlp_pkg::MASK_W-1:0]    o_long_press_mask,
    output logic                           o_user_activity
);

    // configuration registers
    logic [kdlp_pkg::CFG_W-1:0]  r_debounce_ms;
    logic [kdlp_pkg::CFG_W-1:0]  r_long_press_ms;
    logic [kdlp_pkg::MASK_W-1:0] r_polarity_mask;
    logic [kdlp_pkg::WAKE_W-1:0] r_wake_key_index;

    // first word after reset only loads the levels
    logic                        r_primed;

    logic                        accept;
    kdlp_pkg::t_lane_ctl         lane_ctl;
    kdlp_pkg::t_lane_evt [kdlp_pkg::NUM_KEYS-1:0] lane_evt;
    logic [kdlp_pkg::NUM_KEYS-1:0] raw_level;
    logic [kdlp_pkg::NUM_KEYS-1:0] wake_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms     <= kdlp_pkg::RST_DEBOUNCE_MS;
            r_long_press_ms   <= kdlp_pkg::RST_LONG_PRESS_MS;
            r_polarity_mask   <= kdlp_pkg::RST_POLARITY;
            r_wake_key_index  <= kdlp_pkg::RST_WAKE_KEY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kdlp_pkg::REG_DEBOUNCE:   r_debounce_ms     <= i_cfg_data;
                kdlp_pkg::REG_LONG_PRESS: r_long_press_ms   <= i_cfg_data;
                kdlp_pkg::REG_POLARITY:   r_polarity_mask   <= i_cfg_data[kdlp_pkg::MASK_W-1:0];
                kdlp_pkg::REG_WAKE_KEY:   r_wake_key_index  <= i_cfg_data[kdlp_pkg::WAKE_W-1:0];
                default: ;
            endcase
        end
    end

    // Take a new word whenever the output register is empty or being drained.
    assign o_in_ready = ~o_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (accept) begin
            r_primed <= 1'b1;
        end
    end

    // Values shared by every lane for the current word.
    always_comb begin
        lane_ctl.primed     = r_primed;
        lane_ctl.bl_off     = i_backlight_off;
        lane_ctl.elapsed    = i_elapsed_ms;
        lane_ctl.debounce   = r_debounce_ms;
        lane_ctl.long_press = r_long_press_ms;
    end

    // Correct polarity per key, and flag the wake key. An index that names no
    // key leaves every wake bit low.
    always_comb begin
        for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin
            raw_level[k] = i_pin_levels[k] ^ r_polarity_mask[k];
            wake_sel[k]  = (int'(r_wake_key_index) == k);
        end
    end

    // One lane per key, all advancing on the same accepted word.
    for (genvar g = 0; g < kdlp_pkg::NUM_KEYS; g++) begin : g_lane
        kdlp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (accept),
            .i_raw    (raw_level[g]),
            .i_is_wake(wake_sel[g]),
            .i_ctl    (lane_ctl),
            .o_evt    (lane_evt[g])
        );
    end

    // Merge lane findings into the registered output word.
    kdlp_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_evt             (lane_evt),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_short_press_mask(o_short_press_mask),
        .o_long_press_mask (o_long_press_mask),
        .o_user_activity   (o_user_activity)
    );

endmodule

// File: rtl/core/kdlp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_lane: debounce and press timing for one key
// Holds the per-key timers and flags, advances them on each accepted word
// and reports short press, long press and activity for that word.
// ----------------------------------------------------------------------------
module kdlp_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_raw,
    input  logic                i_is_wake,
    input  kdlp_pkg::t_lane_ctl i_ctl,
    output kdlp_pkg::t_lane_evt o_evt
);

    logic            r_last_raw,  n_last_raw;
    logic            r_confirmed, n_confirmed;
    kdlp_pkg::t_timer r_since,    n_since;
    kdlp_pkg::t_timer r_held,     n_held;
    logic            r_active,    n_active;
    logic            r_long_done, n_long_done;
    logic            r_swallowed, n_swallowed;

    logic            confirm;
    logic            held_short;
    logic            held_long;

    always_comb begin
        n_last_raw  = r_last_raw;
        n_confirmed = r_confirmed;
        n_since     = r_since;
        n_held      = r_held;
        n_active    = r_active;
        n_long_done = r_long_done;
        n_swallowed = r_swallowed;
        o_evt       = '0;
        confirm     = 1'b0;
        held_short  = 1'b0;
        held_long   = 1'b0;

        if (!i_ctl.primed) begin
            // first word only loads the level
            n_last_raw = i_raw;
            n_since    = '0;
        end else begin
            n_since = kdlp_pkg::sat_add(r_since, i_ctl.elapsed);
            if (r_active) begin
                n_held = kdlp_pkg::sat_add(r_held, i_ctl.elapsed);
            end

            // raw edge restarts the stability timer
            if (i_raw != r_last_raw) begin
                n_last_raw  = i_raw;
                n_since     = '0;
                n_swallowed = i_raw & i_is_wake & i_ctl.bl_off;
            end

            confirm    = (kdlp_pkg::CMP_W'(n_since) >= kdlp_pkg::CMP_W'(i_ctl.debounce))
                         && (i_raw != r_confirmed);
            held_short = kdlp_pkg::CMP_W'(n_held) < kdlp_pkg::CMP_W'(i_ctl.long_press);

            if (confirm) begin
                n_confirmed = i_raw;
                if (i_raw) begin
                    n_held      = '0;
                    n_active    = 1'b1;
                    n_long_done = 1'b0;
                end else begin
                    o_evt.short_ev = r_active & ~r_long_done & ~n_swallowed & held_short;
                    n_active    = 1'b0;
                    n_long_done = 1'b0;
                    n_swallowed = 1'b0;
                    n_held      = '0;
                end
            end

            held_long = kdlp_pkg::CMP_W'(n_held) >= kdlp_pkg::CMP_W'(i_ctl.long_press);
            if (n_confirmed && n_active && !n_long_done && held_long) begin
                n_long_done   = 1'b1;
                o_evt.long_ev = ~n_swallowed;
            end

            o_evt.activity = i_raw | n_confirmed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b0;
            r_confirmed <= 1'b0;
            r_since     <= '0;
            r_held      <= '0;
            r_active    <= 1'b0;
            r_long_done <= 1'b0;
            r_swallowed <= 1'b0;
        end else if (i_accept) begin
            r_last_raw  <= n_last_raw;
            r_confirmed <= n_confirmed;
            r_since     <= n_since;
            r_held      <= n_held;
            r_active    <= n_active;
            r_long_done <= n_long_done;
            r_swallowed <= n_swallowed;
        end
    end

endmodule

// File: rtl/core/kdlp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_merge: combine lane results into one output word
// Packs the per-key event bits, reduces activity and holds the word in an
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module kdlp_merge (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_accept,
    input  kdlp_pkg::t_lane_evt [kdlp_pkg::NUM_KEYS-1:0] i_evt,
    input  logic                                       i_out_ready,
    output logic                                       o_out_valid,
    output logic [kdlp_pkg::MASK_W-1:0]                o_short_press_mask,
    output logic [kdlp_pkg::MASK_W-1:0]                o_long_press_mask,
    output logic                                       o_user_activity
);

    logic [kdlp_pkg::NUM_KEYS-1:0] short_bits;
    logic [kdlp_pkg::NUM_KEYS-1:0] long_bits;
    logic [kdlp_pkg::NUM_KEYS-1:0] act_bits;

    logic                          r_valid;
    logic [kdlp_pkg::MASK_W-1:0]   r_short;
    logic [kdlp_pkg::MASK_W-1:0]   r_long;
    logic                          r_activity;

    always_comb begin
        for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin
            short_bits[k] = i_evt[k].short_ev;
            long_bits[k]  = i_evt[k].long_ev;
            act_bits[k]   = i_evt[k].activity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_short    <= kdlp_pkg::MASK_W'(short_bits);
            r_long     <= kdlp_pkg::MASK_W'(long_bits);
            r_activity <= |act_bits;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_short_press_mask = r_short;
    assign o_long_press_mask  = r_long;
    assign o_user_activity    = r_activity;

endmodule

// File: rtl/core/kdlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_checker: port-level checks for the key debounce unit
// Watches the handshakes and result word over time; bound to the top level.
// ----------------------------------------------------------------------------
module kdlp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [kdlp_pkg::MASK_W-1:0]    o_short_press_mask,
    input logic [kdlp_pkg::MASK_W-1:0]    o_long_press_mask,
    input logic                           o_user_activity
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_short_press_mask) && $stable(o_long_press_mask))
        else $error("result word dropped or changed while stalled");

    // input side is free whenever the output register can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output register state");

    // every accepted word yields a result on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted word gave no result");

    // a key cannot both release and hold in one word
    a_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_short_press_mask & o_long_press_mask) == '0))
        else $error("short and long press on the same key");

    // a long press means a key is held
    a_long_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_long_press_mask != '0) |-> o_user_activity)
        else $error("long press without activity");

endmodule

bind key_debounce_long_press_unit kdlp_checker u_kdlp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_short_press_mask(o_short_press_mask),
    .o_long_press_mask (o_long_press_mask),
    .o_user_activity   (o_user_activity)
);

// File: dv/tb_key_debounce_long_press_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_long_press_unit: self-checking bench for the key debounce unit
// Drives poll samples through the valid/ready input, predicts every result
// word with a cycle-free model of the debounce and press logic, and compares
// each word taken from the output against the oldest prediction. A directed
// walk of press gestures comes first, then register phases with random
// gestures, bounce and noise, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_key_debounce_long_press_unit;

    localparam int NKEYS = kdlp_pkg::NUM_KEYS;
    localparam int TW    = kdlp_pkg::TIMER_BITS;
    localparam int MW    = kdlp_pkg::MASK_W;
    localparam int EW    = kdlp_pkg::ELAPSED_W;

    localparam int DIRECTED_ROWS  = 25;
    localparam int FIXED_SETS     = 4;
    localparam int PHASES         = 7;
    localparam int ITEMS_PER_PHASE = 40;

    // one result word
    typedef struct packed {
        logic [MW-1:0] short_mask;
        logic [MW-1:0] long_mask;
        logic          activity;
    } t_key_events;

    // one row of the directed walk; result is used only when typed is set
    typedef struct packed {
        logic [MW-1:0] pins;
        logic [EW-1:0] el;
        logic          bl;
        logic          typed;
        t_key_events   result;
    } t_stim_row;

    // one full register setting
    typedef struct packed {
        logic [kdlp_pkg::CFG_W-1:0] debounce;
        logic [kdlp_pkg::CFG_W-1:0] long_press;
        logic [MW-1:0]              polarity;
        logic [1:0]                 wake_key;
    } t_reg_set;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [kdlp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [kdlp_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [MW-1:0]                  i_pin_levels = '0;
    logic [EW-1:0]                  i_elapsed_ms = '0;
    logic                           i_backlight_off = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [MW-1:0]                  o_short_press_mask;
    logic [MW-1:0]                  o_long_press_mask;
    logic                           o_user_activity;

    // typed expectation that travels with the word on the input
    logic        word_typed = 1'b0;
    t_key_events word_result = '0;

    key_debounce_long_press_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_pin_levels       (i_pin_levels),
        .i_elapsed_ms       (i_elapsed_ms),
        .i_backlight_off    (i_backlight_off),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_short_press_mask (o_short_press_mask),
        .o_long_press_mask  (o_long_press_mask),
        .o_user_activity    (o_user_activity)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Press model: registers, per-key state and the events queue
    // ------------------------------------------------------------------
    logic [kdlp_pkg::CFG_W-1:0] cfg_debounce;
    logic [kdlp_pkg::CFG_W-1:0] cfg_long_press;
    logic [MW-1:0]              cfg_polarity;
    logic [1:0]                 cfg_wake_key;

    logic                 keys_primed;
    logic                 key_last_raw  [NKEYS];
    logic                 key_confirmed [NKEYS];
    kdlp_pkg::t_timer     key_since     [NKEYS];
    kdlp_pkg::t_timer     key_held      [NKEYS];
    logic                 key_active    [NKEYS];
    logic                 key_long_done [NKEYS];
    logic                 key_swallowed [NKEYS];

    t_key_events pending_events[$];
    int          fail_count = 0;
    int          words_sent = 0;
    bit          no_gaps = 1'b0;
    bit          long_hold_done = 1'b0;

    function automatic kdlp_pkg::t_timer timer_advance(kdlp_pkg::t_timer t, logic [EW-1:0] e);
        logic [TW:0] sum;
        sum = {1'b0, t} + {{(TW + 1 - EW){1'b0}}, e};
        return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
    endfunction

    function automatic void clear_keys();
        cfg_debounce   = kdlp_pkg::RST_DEBOUNCE_MS;
        cfg_long_press = kdlp_pkg::RST_LONG_PRESS_MS;
        cfg_polarity   = kdlp_pkg::RST_POLARITY;
        cfg_wake_key   = kdlp_pkg::RST_WAKE_KEY;
        keys_primed    = 1'b0;
        for (int k = 0; k < NKEYS; k++) begin
            key_last_raw[k]  = 1'b0;
            key_confirmed[k] = 1'b0;
            key_since[k]     = '0;
            key_held[k]      = '0;
            key_active[k]    = 1'b0;
            key_long_done[k] = 1'b0;
            key_swallowed[k] = 1'b0;
        end
    endfunction

    function automatic void apply_reg(logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                                      logic [kdlp_pkg::CFG_W-1:0] data);
        case (idx)
            kdlp_pkg::REG_DEBOUNCE:   cfg_debounce   = data;
            kdlp_pkg::REG_LONG_PRESS: cfg_long_press = data;
            kdlp_pkg::REG_POLARITY:   cfg_polarity   = data[MW-1:0];
            kdlp_pkg::REG_WAKE_KEY:   cfg_wake_key   = data[1:0];
            default: ;
        endcase
    endfunction

    // Advance every key by one poll sample and return the events it causes.
    function automatic t_key_events press_events(logic [MW-1:0] pins, logic [EW-1:0] el,
                                                 logic bl);
        t_key_events ev;
        logic        raw;
        ev = '0;
        for (int k = 0; k < NKEYS; k++) begin
            raw = pins[k] ^ cfg_polarity[k];
            if (!keys_primed) begin
                // first sample only loads the levels
                key_last_raw[k] = raw;
                key_since[k]    = '0;
            end else begin
                key_since[k] = timer_advance(key_since[k], el);
                if (key_active[k])
                    key_held[k] = timer_advance(key_held[k], el);
                // raw edge: restart stability timer, latch the wake swallow
                if (raw != key_last_raw[k]) begin
                    key_last_raw[k]  = raw;
                    key_since[k]     = '0;
                    key_swallowed[k] = raw && (k == cfg_wake_key) && bl;
                end
                if (key_since[k] >= cfg_debounce && raw != key_confirmed[k]) begin
                    key_confirmed[k] = raw;
                    if (raw) begin
                        key_held[k]      = '0;
                        key_active[k]    = 1'b1;
                        key_long_done[k] = 1'b0;
                    end else begin
                        if (key_active[k] && !key_long_done[k] && !key_swallowed[k]
                            && key_held[k] < cfg_long_press)
                            ev.short_mask[k] = 1'b1;
                        key_active[k]    = 1'b0;
                        key_long_done[k] = 1'b0;
                        key_swallowed[k] = 1'b0;
                        key_held[k]      = '0;
                    end
                end
                if (key_confirmed[k] && key_active[k] && !key_long_done[k]
                    && key_held[k] >= cfg_long_press) begin
                    key_long_done[k] = 1'b1;
                    if (!key_swallowed[k])
                        ev.long_mask[k] = 1'b1;
                end
                if (raw != key_confirmed[k] || key_confirmed[k])
                    ev.activity = 1'b1;
            end
        end
        keys_primed = 1'b1;
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the
    // edge's own updates land, so handshakes are seen exactly once.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_key_events got;
        t_key_events want;
        t_key_events pred;
        if (!i_rst_n) begin
            clear_keys();
        end else begin
            if (i_cfg_we)
                apply_reg(i_cfg_index, i_cfg_data);
            // check the outgoing word before queueing a new prediction
            if (o_out_valid && i_out_ready) begin
                got = '{o_short_press_mask, o_long_press_mask, o_user_activity};
                if (pending_events.size() == 0) begin
                    $display("%0t: result word with nothing expected: got %h", $time, got);
                    fail_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (got.short_mask !== want.short_mask) begin
                        $display("%0t: short_press_mask expected %b got %b",
                                 $time, want.short_mask, got.short_mask);
                        fail_count++;
                    end
                    if (got.long_mask !== want.long_mask) begin
                        $display("%0t: long_press_mask expected %b got %b",
                                 $time, want.long_mask, got.long_mask);
                        fail_count++;
                    end
                    if (got.activity !== want.activity) begin
                        $display("%0t: user_activity expected %b got %b",
                                 $time, want.activity, got.activity);
                        fail_count++;
                    end
                end
            end
            // always advance the model; a typed row overrides its prediction
            if (i_in_valid && o_in_ready) begin
                pred = press_events(i_pin_levels, i_elapsed_ms, i_backlight_off);
                pending_events.push_back(word_typed ? word_result : pred);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: alternate ready runs and stalls of random length
    // ------------------------------------------------------------------
    int sink_hold = 0;

    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            sink_hold   <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                        : $urandom_range(8, 40);
        end else begin
            i_out_ready <= 1'b1;
            sink_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(0, 20);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Present one sample word and hold it until taken. Returns at the edge
    // that took it (valid still high) or after the idle gap (valid low).
    task automatic send_word(logic [MW-1:0] pins, logic [EW-1:0] el, logic bl,
                             logic typed, t_key_events result);
        int gap;
        i_in_valid      <= 1'b1;
        i_pin_levels    <= pins;
        i_elapsed_ms    <= el;
        i_backlight_off <= bl;
        word_typed      <= typed;
        word_result     <= result;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(logic [MW-1:0] pins, logic [EW-1:0] el, logic bl);
        send_word(pins, el, bl, 1'b0, '0);
    endtask

    // Drop valid and wait until every predicted word has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
                             logic [kdlp_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Upper data bits of the narrow registers are random: they must be dropped.
    task automatic program_regs(t_reg_set s);
        logic [kdlp_pkg::CFG_W-1:0] junk;
        junk = kdlp_pkg::CFG_W'($urandom_range(0, 16'hFFFF));
        write_reg(kdlp_pkg::REG_DEBOUNCE, s.debounce);
        write_reg(kdlp_pkg::REG_LONG_PRESS, s.long_press);
        write_reg(kdlp_pkg::REG_POLARITY, {junk[15:MW], s.polarity});
        write_reg(kdlp_pkg::REG_WAKE_KEY, {junk[15:2], s.wake_key});
        i_cfg_we <= 1'b0;
    endtask

    // One gesture: optional bounce, then a stable pressed set held for a
    // while. Now and then a burst of pure noise instead.
    task automatic play_gesture();
        logic [MW-1:0] pressed;
        logic [MW-1:0] pins;
        int            n_bounce;
        int            n_hold;
        int            el_max;
        int            r;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 4))
                send_sample(MW'($urandom_range(0, 7)), EW'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
        end else begin
            pressed  = MW'($urandom_range(0, 7));
            pins     = pressed ^ cfg_polarity;
            n_bounce = $urandom_range(0, 3);
            r        = $urandom_range(0, 99);
            // mostly short holds; at most one very long hold, which can run the timers to saturation
            n_hold   = (r < 70) ? $urandom_range(1, 12)
                     : (r < 97 || long_hold_done) ? $urandom_range(13, 40)
                     : $urandom_range(260, 300);
            if (n_hold > 40)
                long_hold_done = 1'b1;
            r        = $urandom_range(0, 2);
            el_max   = (r == 0) ? 8 : (r == 1) ? 64 : 255;
            repeat (n_bounce)
                send_sample(MW'($urandom_range(0, 7)), EW'($urandom_range(0, 10)),
                            $urandom_range(0, 3) == 0);
            repeat (n_hold)
                send_sample(pins, EW'($urandom_range(0, el_max)), $urandom_range(0, 3) == 0);
        end
    endtask

    // Directed walk under the reset registers (inverted polarity on keys 0
    // and 2, wake key 1): pins 3'b101 means nothing pressed.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // first sample after reset only loads the levels
        '{3'b101, 8'd0,   1'b0, 1'b1, '{3'b000, 3'b000, 1'b0}},
        // key 0: press, confirm, release, confirm release -> short
        '{3'b100, 8'd10,  1'b0, 1'b0, '0},
        '{3'b100, 8'd255, 1'b0, 1'b0, '0},
        '{3'b101, 8'd5,   1'b0, 1'b0, '0},
        '{3'b101, 8'd30,  1'b0, 1'b0, '{3'b001, 3'b000, 1'b0}},
        // wake key pressed with backlight off: long hold stays silent
        '{3'b111, 8'd0,   1'b1, 1'b0, '0},
        '{3'b111, 8'd255, 1'b0, 1'b0, '0},
        '{3'b111, 8'd255, 1'b0, 1'b0, '0},
        '{3'b111, 8'd255, 1'b0, 1'b0, '0},
        '{3'b111, 8'd255, 1'b0, 1'b0, '0},
        '{3'b111, 8'd255, 1'b0, 1'b0, '0},
        '{3'b111, 8'd255, 1'b0, 1'b0, '0},
        '{3'b111, 8'd255, 1'b0, 1'b0, '0},
        '{3'b101, 8'd1,   1'b0, 1'b0, '0},
        '{3'b101, 8'd25,  1'b0, 1'b0, '0},
        // key 2: backlight off does not matter, long press fires once
        '{3'b001, 8'd200, 1'b1, 1'b0, '0},
        '{3'b001, 8'd255, 1'b0, 1'b0, '0},
        '{3'b001, 8'd255, 1'b0, 1'b0, '0},
        '{3'b001, 8'd255, 1'b0, 1'b0, '0},
        '{3'b001, 8'd255, 1'b0, 1'b0, '0},
        '{3'b001, 8'd255, 1'b0, 1'b0, '0},
        '{3'b001, 8'd255, 1'b0, 1'b0, '0},
        '{3'b001, 8'd255, 1'b0, 1'b0, '0},
        '{3'b101, 8'd255, 1'b0, 1'b0, '0},
        '{3'b101, 8'd255, 1'b0, 1'b0, '0}
    };

    // Extremes first: zero debounce with zero long press and a wake index
    // naming no key, then debounce, long press and polarity at their maximum.
    t_reg_set fixed_sets [FIXED_SETS] = '{
        '{16'd0,     16'd0,     3'd0, 2'd3},
        '{16'hFFFF,  16'hFFFF,  3'd7, 2'd0},
        '{16'd5,     16'd1,     3'd2, 2'd2},
        '{16'd20,    16'd300,   3'd5, 2'd1}
    };

    initial begin
        t_reg_set set;
        int       phase_end;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_word(directed_rows[n].pins, directed_rows[n].el, directed_rows[n].bl,
                      directed_rows[n].typed, directed_rows[n].result);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p < FIXED_SETS) begin
                set = fixed_sets[p];
            end else begin
                set.debounce   = kdlp_pkg::CFG_W'($urandom_range(0, 60));
                set.long_press = kdlp_pkg::CFG_W'($urandom_range(0, 2500));
                set.polarity   = MW'($urandom_range(0, 7));
                set.wake_key   = 2'($urandom_range(0, 3));
            end
            program_regs(set);
            // some phases run back to back with no sender gaps
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_end = words_sent + ITEMS_PER_PHASE;
            while (words_sent < phase_end) begin
                play_gesture();
                // hold off the sender until the output has fully caught up
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/kdlp_pkg.sv
rtl/core/kdlp_lane.sv
rtl/core/kdlp_merge.sv
rtl/core/key_debounce_long_press_unit.sv
rtl/core/kdlp_checker.sv
dv/tb_key_debounce_long_press_unit.sv
